### hdl/acc16_pkg.sv
package acc16_pkg;

    // Default memory address width
    localparam int ADDR_BITS_DEF = 16;

    localparam logic [15:0] WORD_MAX = 16'hFFFF;
    localparam logic [15:0] STACK_TOP = WORD_MAX;

    // Item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_EXEC  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Operand modes
    localparam logic [3:0] MODE_REG = 4'd0;
    localparam logic [3:0] MODE_IND = 4'd1;
    localparam logic [3:0] MODE_IMM = 4'd2;

    // Opcodes
    localparam logic [7:0] OP_HLT = 8'd0;
    localparam logic [7:0] OP_ADD = 8'd1;
    localparam logic [7:0] OP_SUB = 8'd2;
    localparam logic [7:0] OP_AND = 8'd3;
    localparam logic [7:0] OP_NOT = 8'd4;
    localparam logic [7:0] OP_IOR = 8'd5;
    localparam logic [7:0] OP_CMP = 8'd6;
    localparam logic [7:0] OP_JMP = 8'd7;
    localparam logic [7:0] OP_JEQ = 8'd8;
    localparam logic [7:0] OP_JGT = 8'd9;
    localparam logic [7:0] OP_JLT = 8'd10;
    localparam logic [7:0] OP_STR = 8'd11;
    localparam logic [7:0] OP_LDR = 8'd12;
    localparam logic [7:0] OP_MOV = 8'd13;
    localparam logic [7:0] OP_PSH = 8'd14;
    localparam logic [7:0] OP_POP = 8'd15;
    localparam logic [7:0] OP_PSA = 8'd16;
    localparam logic [7:0] OP_POA = 8'd17;
    localparam logic [7:0] OP_JSR = 8'd18;
    localparam logic [7:0] OP_RET = 8'd19;
    localparam logic [7:0] OP_SSB = 8'd20;
    localparam logic [7:0] OP_RSP = 8'd21;
    localparam logic [7:0] OP_JOF = 8'd22;
    localparam logic [7:0] OP_JUF = 8'd23;
    localparam logic [7:0] OP_CLF = 8'd24;
    localparam logic [7:0] OP_SHR = 8'd25;
    localparam logic [7:0] OP_SHL = 8'd26;
    localparam logic [7:0] OP_NOP = 8'd27;

    // Flag bits
    localparam logic [4:0] FL_GT = 5'h01;
    localparam logic [4:0] FL_LT = 5'h02;
    localparam logic [4:0] FL_EQ = 5'h04;
    localparam logic [4:0] FL_UF = 5'h08;
    localparam logic [4:0] FL_OF = 5'h10;

    // Datapath micro-operations
    typedef enum logic [4:0] {
        UOP_NONE,
        UOP_CLEAR,
        UOP_LATCH,
        UOP_MWRITE,
        UOP_MREAD,
        UOP_FETCH0,
        UOP_FETCH1,
        UOP_FETCH2,
        UOP_EXEC,
        UOP_POP2,
        UOP_RET2,
        UOP_PSA,
        UOP_POA_RD,
        UOP_POA_WR,
        UOP_JSR_INIT,
        UOP_JSR_RD,
        UOP_JSR_WR,
        UOP_JSR_END,
        UOP_FINISH
    } t_uop;

    typedef struct packed {
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic       clr_last;
        logic       halted;
        logic [1:0] kind;
        logic [7:0] opcode;
        logic       cnt_last;
        logic       jsr_skip;
        logic       jsr_last;
    } t_stat;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_KIND,
        S_F1,
        S_F2,
        S_EX,
        S_POP2,
        S_RET2,
        S_PSA,
        S_POA_RD,
        S_POA_WR,
        S_JINIT,
        S_JRD,
        S_JWR,
        S_JEND,
        S_FIN
    } t_state;

endpackage

### hdl/acc16_dp.sv
module acc16_dp #(
    parameter int ADDR_BITS = acc16_pkg::ADDR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  acc16_pkg::t_cmd    i_cmd,
    output acc16_pkg::t_stat   o_stat,
    input  logic [1:0]         i_kind,
    input  logic [15:0]        i_address,
    input  logic [15:0]        i_write_data,
    output logic               o_halted,
    output logic               o_bad_opcode,
    output logic [15:0]        o_prog_counter,
    output logic [15:0]        o_accum,
    output logic [15:0]        o_stack_ptr,
    output logic [4:0]         o_flag_bits,
    output logic [15:0]        o_read_data
);

    localparam int MEM_WORDS = 2 ** ADDR_BITS;

    // Architectural state
    logic [15:0] r_regs [16];
    logic [15:0] r_pc, n_pc;
    logic [15:0] r_sp, n_sp;
    logic [15:0] r_floor, n_floor;
    logic [4:0]  r_flags, n_flags;
    logic        r_halt, n_halt;
    logic        r_err, n_err;

    // Working registers
    logic [16:0]          r_cnt, n_cnt;
    logic [ADDR_BITS-1:0] r_clr, n_clr;
    logic [15:0]          r_ins, r_nxt, r_n, r_rdata;
    logic [1:0]           r_kind;
    logic [15:0]          r_addr, r_wd;

    // Output registers
    logic        r_o_halted, r_o_bad;
    logic [15:0] r_o_pc, r_o_acc, r_o_sp, r_o_rd;
    logic [4:0]  r_o_flags;

    // Memory port and register-file ports
    logic [15:0] r_mem [MEM_WORDS];
    logic        mem_we, mem_re;
    logic [15:0] mem_a, mem_wd;
    logic        reg_we;
    logic [3:0]  reg_wa, reg_ra;
    logic [15:0] reg_wd, reg_rv;

    // Decode fields
    logic [7:0]  op;
    logic [3:0]  fm, fr;
    logic [15:0] acc, opd, opd_pc, pc1, pc2, sp_pop;
    logic        mode_ok;
    logic [16:0] sum, jsr_lim;
    logic [4:0]  jmask;

    assign op  = r_ins[15:8];
    assign fm  = r_ins[7:4];
    assign fr  = r_ins[3:0];
    assign acc = r_regs[0];
    assign pc1 = r_pc + 16'd1;
    assign pc2 = r_pc + 16'd2;
    assign sp_pop = (r_sp != r_floor) ? r_sp + 16'd1 : r_sp;
    assign jsr_lim = {r_n[15], r_n} + 17'd2;

    // Pick the register-file read address
    always_comb begin
        if (i_cmd.uop == acc16_pkg::UOP_PSA) begin
            reg_ra = r_cnt[3:0];
        end else if (op == acc16_pkg::OP_MOV) begin
            reg_ra = fm;
        end else begin
            reg_ra = fr;
        end
    end
    assign reg_rv = r_regs[reg_ra];

    // Resolve the operand by mode
    always_comb begin
        mode_ok = 1'b1;
        unique case (fm)
            acc16_pkg::MODE_REG: begin
                opd    = reg_rv;
                opd_pc = pc1;
            end
            acc16_pkg::MODE_IND: begin
                opd    = r_rdata;
                opd_pc = pc2;
            end
            acc16_pkg::MODE_IMM: begin
                opd    = r_nxt;
                opd_pc = pc2;
            end
            default: begin
                opd     = 16'd0;
                opd_pc  = r_pc;
                mode_ok = 1'b0;
            end
        endcase
    end
    assign sum = {1'b0, acc} + {1'b0, opd};

    // Flag tested by a conditional jump
    always_comb begin
        unique case (op) inside
            acc16_pkg::OP_JEQ: jmask = acc16_pkg::FL_EQ;
            acc16_pkg::OP_JGT: jmask = acc16_pkg::FL_GT;
            acc16_pkg::OP_JLT: jmask = acc16_pkg::FL_LT;
            acc16_pkg::OP_JOF: jmask = acc16_pkg::FL_OF;
            default:           jmask = acc16_pkg::FL_UF;
        endcase
    end

    // Carry out the micro-operation
    always_comb begin
        n_pc    = r_pc;
        n_sp    = r_sp;
        n_floor = r_floor;
        n_flags = r_flags;
        n_halt  = r_halt;
        n_err   = r_err;
        n_cnt   = r_cnt;
        n_clr   = r_clr;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        mem_a   = r_pc;
        mem_wd  = reg_rv;
        reg_we  = 1'b0;
        reg_wa  = fr;
        reg_wd  = r_rdata;
        unique case (i_cmd.uop)
            acc16_pkg::UOP_CLEAR: begin
                mem_we = 1'b1;
                mem_a  = 16'(r_clr);
                mem_wd = 16'd0;
                n_clr  = r_clr + 1'b1;
            end
            acc16_pkg::UOP_MWRITE: begin
                mem_we = 1'b1;
                mem_a  = r_addr;
                mem_wd = r_wd;
            end
            acc16_pkg::UOP_MREAD: begin
                mem_re = 1'b1;
                mem_a  = r_addr;
            end
            acc16_pkg::UOP_FETCH0: begin
                mem_re = 1'b1;
            end
            acc16_pkg::UOP_FETCH1: begin
                mem_re = 1'b1;
                mem_a  = pc1;
            end
            acc16_pkg::UOP_FETCH2: begin
                mem_re = 1'b1;
                mem_a  = r_rdata;
            end
            acc16_pkg::UOP_EXEC: begin
                n_cnt = 17'd0;
                unique case (op) inside
                    acc16_pkg::OP_HLT: n_halt = 1'b1;
                    acc16_pkg::OP_ADD: begin
                        reg_we = 1'b1;
                        reg_wa = 4'd0;
                        reg_wd = sum[15:0];
                        n_pc   = opd_pc;
                        if (sum[16]) n_flags = r_flags | acc16_pkg::FL_OF;
                    end
                    acc16_pkg::OP_SUB: begin
                        reg_we = 1'b1;
                        reg_wa = 4'd0;
                        reg_wd = acc - opd;
                        n_pc   = opd_pc;
                        if (opd > acc) n_flags = r_flags | acc16_pkg::FL_UF;
                    end
                    acc16_pkg::OP_AND: begin
                        reg_we = mode_ok;
                        reg_wa = 4'd0;
                        reg_wd = acc & opd;
                        n_pc   = opd_pc;
                    end
                    acc16_pkg::OP_NOT: begin
                        reg_we = 1'b1;
                        reg_wa = 4'd0;
                        reg_wd = ~acc;
                        n_pc   = pc1;
                    end
                    acc16_pkg::OP_IOR: begin
                        reg_we = mode_ok;
                        reg_wa = 4'd0;
                        reg_wd = acc | opd;
                        n_pc   = opd_pc;
                    end
                    acc16_pkg::OP_CMP: begin
                        n_pc = opd_pc;
                        if (acc > opd) begin
                            n_flags = r_flags | acc16_pkg::FL_GT;
                        end else if (acc < opd) begin
                            n_flags = r_flags | acc16_pkg::FL_LT;
                        end else begin
                            n_flags = r_flags | acc16_pkg::FL_EQ;
                        end
                    end
                    acc16_pkg::OP_JMP: n_pc = r_nxt;
                    acc16_pkg::OP_JEQ, acc16_pkg::OP_JGT, acc16_pkg::OP_JLT,
                    acc16_pkg::OP_JOF, acc16_pkg::OP_JUF: begin
                        if ((r_flags & jmask) != 5'd0) begin
                            n_pc    = r_nxt;
                            n_flags = r_flags & ~jmask;
                        end else begin
                            n_pc = pc2;
                        end
                    end
                    acc16_pkg::OP_STR: begin
                        mem_we = 1'b1;
                        mem_a  = r_nxt;
                        mem_wd = reg_rv;
                        n_pc   = pc2;
                    end
                    acc16_pkg::OP_LDR: begin
                        reg_we = 1'b1;
                        n_pc   = pc2;
                    end
                    acc16_pkg::OP_MOV: begin
                        reg_we = 1'b1;
                        reg_wd = reg_rv;
                        n_pc   = pc1;
                    end
                    acc16_pkg::OP_PSH: begin
                        mem_we = 1'b1;
                        mem_a  = r_sp;
                        mem_wd = opd;
                        n_sp   = r_sp - 16'd1;
                        n_pc   = opd_pc;
                    end
                    acc16_pkg::OP_POP: begin
                        n_sp   = sp_pop;
                        mem_re = 1'b1;
                        mem_a  = sp_pop;
                    end
                    acc16_pkg::OP_PSA, acc16_pkg::OP_POA: begin
                        n_cnt = 17'd0;
                    end
                    acc16_pkg::OP_JSR: begin
                        mem_re = 1'b1;
                        mem_a  = r_sp + 16'd1;
                    end
                    acc16_pkg::OP_RET: begin
                        n_sp   = r_sp + 16'd1;
                        mem_re = 1'b1;
                        mem_a  = r_sp + 16'd1;
                    end
                    acc16_pkg::OP_SSB: begin
                        if (fm == acc16_pkg::MODE_REG) begin
                            n_floor = r_rdata;
                        end else if (fm == acc16_pkg::MODE_IND) begin
                            n_floor = r_nxt;
                        end
                        n_pc = pc2;
                    end
                    acc16_pkg::OP_RSP: begin
                        n_sp = r_floor;
                        n_pc = pc1;
                    end
                    acc16_pkg::OP_CLF: begin
                        n_flags = 5'd0;
                        n_pc    = pc1;
                    end
                    acc16_pkg::OP_SHR: begin
                        reg_we = 1'b1;
                        reg_wa = 4'd0;
                        reg_wd = {1'b0, acc[15:1]};
                        n_pc   = pc1;
                    end
                    acc16_pkg::OP_SHL: begin
                        reg_we = 1'b1;
                        reg_wa = 4'd0;
                        reg_wd = {acc[14:0], 1'b0};
                        n_pc   = pc1;
                    end
                    acc16_pkg::OP_NOP: n_pc = pc1;
                    default: begin
                        n_halt = 1'b1;
                        n_err  = 1'b1;
                    end
                endcase
            end
            acc16_pkg::UOP_POP2: begin
                if (fm == acc16_pkg::MODE_REG) begin
                    reg_we = 1'b1;
                    n_pc   = pc1;
                end else if (fm == acc16_pkg::MODE_IND) begin
                    mem_we = 1'b1;
                    mem_a  = r_nxt;
                    mem_wd = r_rdata;
                    n_pc   = pc2;
                end
            end
            acc16_pkg::UOP_RET2: n_pc = r_rdata;
            acc16_pkg::UOP_PSA: begin
                mem_we = 1'b1;
                mem_a  = r_sp;
                mem_wd = reg_rv;
                n_sp   = r_sp - 16'd1;
                n_cnt  = r_cnt + 17'd1;
                if (r_cnt[3:0] == 4'hF) n_pc = pc1;
            end
            acc16_pkg::UOP_POA_RD: begin
                n_sp   = r_sp + 16'd1;
                mem_re = 1'b1;
                mem_a  = r_sp + 16'd1;
            end
            acc16_pkg::UOP_POA_WR: begin
                reg_we = 1'b1;
                reg_wa = ~r_cnt[3:0];
                n_cnt  = r_cnt + 17'd1;
                if (r_cnt[3:0] == 4'hF) n_pc = pc1;
            end
            acc16_pkg::UOP_JSR_INIT: n_cnt = 17'd0;
            acc16_pkg::UOP_JSR_RD: begin
                mem_re = 1'b1;
                mem_a  = r_sp + r_cnt[15:0] + 16'd1;
            end
            acc16_pkg::UOP_JSR_WR: begin
                mem_we = 1'b1;
                mem_a  = r_sp + r_cnt[15:0];
                mem_wd = r_rdata;
                n_cnt  = r_cnt + 17'd1;
            end
            acc16_pkg::UOP_JSR_END: begin
                mem_we = 1'b1;
                mem_a  = r_sp + r_n + 16'd1;
                mem_wd = pc2;
                n_sp   = r_sp - 16'd1;
                n_pc   = r_nxt;
            end
            default: begin
            end
        endcase
    end

    // Main store: one port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_a[ADDR_BITS-1:0]] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_a[ADDR_BITS-1:0]];
        end
    end

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) r_regs[i] <= 16'd0;
        end else if (reg_we) begin
            r_regs[reg_wa] <= reg_wd;
        end
    end

    // Architectural and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= 16'd0;
            r_sp    <= acc16_pkg::STACK_TOP;
            r_floor <= acc16_pkg::STACK_TOP;
            r_flags <= 5'd0;
            r_halt  <= 1'b0;
            r_err   <= 1'b0;
            r_cnt   <= 17'd0;
            r_clr   <= '0;
        end else begin
            r_pc    <= n_pc;
            r_sp    <= n_sp;
            r_floor <= n_floor;
            r_flags <= n_flags;
            r_halt  <= n_halt;
            r_err   <= n_err;
            r_cnt   <= n_cnt;
            r_clr   <= n_clr;
        end
    end

    // Capture item fields and fetched words
    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == acc16_pkg::UOP_LATCH) begin
            r_kind <= i_kind;
            r_addr <= i_address;
            r_wd   <= i_write_data;
        end
        if (i_cmd.uop == acc16_pkg::UOP_FETCH1) r_ins <= r_rdata;
        if (i_cmd.uop == acc16_pkg::UOP_FETCH2) r_nxt <= r_rdata;
        if (i_cmd.uop == acc16_pkg::UOP_JSR_INIT) r_n <= r_rdata;
    end

    // Load the result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_halted <= 1'b0;
            r_o_bad    <= 1'b0;
        end else if (i_cmd.uop == acc16_pkg::UOP_FINISH) begin
            r_o_halted <= r_halt;
            r_o_bad    <= r_err;
        end
        if (i_cmd.uop == acc16_pkg::UOP_FINISH) begin
            r_o_pc    <= r_pc;
            r_o_acc   <= acc;
            r_o_sp    <= r_sp;
            r_o_flags <= r_flags;
            r_o_rd    <= (r_kind == acc16_pkg::KIND_READ) ? r_rdata : 16'd0;
        end
    end

    assign o_halted       = r_o_halted;
    assign o_bad_opcode   = r_o_bad;
    assign o_prog_counter = r_o_pc;
    assign o_accum        = r_o_acc;
    assign o_stack_ptr    = r_o_sp;
    assign o_flag_bits    = r_o_flags;
    assign o_read_data    = r_o_rd;

    // Report status to the controller
    assign o_stat.clr_last = &r_clr;
    assign o_stat.halted   = r_halt;
    assign o_stat.kind     = r_kind;
    assign o_stat.opcode   = op;
    assign o_stat.cnt_last = (r_cnt[3:0] == 4'hF);
    assign o_stat.jsr_skip = jsr_lim[16] || (jsr_lim == 17'd0);
    assign o_stat.jsr_last = ((r_cnt + 17'd1) == jsr_lim);

endmodule

### hdl/acc16_ctrl.sv
module acc16_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  acc16_pkg::t_stat i_stat,
    output acc16_pkg::t_cmd  o_cmd
);

    acc16_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;

    // State and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= acc16_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd.uop   = acc16_pkg::UOP_NONE;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            acc16_pkg::S_CLEAR: begin
                o_cmd.uop = acc16_pkg::UOP_CLEAR;
                if (i_stat.clr_last) n_state = acc16_pkg::S_IDLE;
            end
            acc16_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.uop = acc16_pkg::UOP_LATCH;
                    n_state   = acc16_pkg::S_KIND;
                end
            end
            acc16_pkg::S_KIND: begin
                n_state = acc16_pkg::S_FIN;
                unique case (i_stat.kind)
                    acc16_pkg::KIND_WRITE: o_cmd.uop = acc16_pkg::UOP_MWRITE;
                    acc16_pkg::KIND_READ:  o_cmd.uop = acc16_pkg::UOP_MREAD;
                    acc16_pkg::KIND_EXEC: begin
                        if (!i_stat.halted) begin
                            o_cmd.uop = acc16_pkg::UOP_FETCH0;
                            n_state   = acc16_pkg::S_F1;
                        end
                    end
                    default: o_cmd.uop = acc16_pkg::UOP_NONE;
                endcase
            end
            acc16_pkg::S_F1: begin
                o_cmd.uop = acc16_pkg::UOP_FETCH1;
                n_state   = acc16_pkg::S_F2;
            end
            acc16_pkg::S_F2: begin
                o_cmd.uop = acc16_pkg::UOP_FETCH2;
                n_state   = acc16_pkg::S_EX;
            end
            acc16_pkg::S_EX: begin
                o_cmd.uop = acc16_pkg::UOP_EXEC;
                unique case (i_stat.opcode) inside
                    acc16_pkg::OP_POP: n_state = acc16_pkg::S_POP2;
                    acc16_pkg::OP_RET: n_state = acc16_pkg::S_RET2;
                    acc16_pkg::OP_PSA: n_state = acc16_pkg::S_PSA;
                    acc16_pkg::OP_POA: n_state = acc16_pkg::S_POA_RD;
                    acc16_pkg::OP_JSR: n_state = acc16_pkg::S_JINIT;
                    default:           n_state = acc16_pkg::S_FIN;
                endcase
            end
            acc16_pkg::S_POP2: begin
                o_cmd.uop = acc16_pkg::UOP_POP2;
                n_state   = acc16_pkg::S_FIN;
            end
            acc16_pkg::S_RET2: begin
                o_cmd.uop = acc16_pkg::UOP_RET2;
                n_state   = acc16_pkg::S_FIN;
            end
            acc16_pkg::S_PSA: begin
                o_cmd.uop = acc16_pkg::UOP_PSA;
                if (i_stat.cnt_last) n_state = acc16_pkg::S_FIN;
            end
            acc16_pkg::S_POA_RD: begin
                o_cmd.uop = acc16_pkg::UOP_POA_RD;
                n_state   = acc16_pkg::S_POA_WR;
            end
            acc16_pkg::S_POA_WR: begin
                o_cmd.uop = acc16_pkg::UOP_POA_WR;
                n_state   = i_stat.cnt_last ? acc16_pkg::S_FIN : acc16_pkg::S_POA_RD;
            end
            acc16_pkg::S_JINIT: begin
                o_cmd.uop = acc16_pkg::UOP_JSR_INIT;
                n_state   = acc16_pkg::S_JRD;
            end
            acc16_pkg::S_JRD: begin
                if (i_stat.jsr_skip) begin
                    n_state = acc16_pkg::S_JEND;
                end else begin
                    o_cmd.uop = acc16_pkg::UOP_JSR_RD;
                    n_state   = acc16_pkg::S_JWR;
                end
            end
            acc16_pkg::S_JWR: begin
                o_cmd.uop = acc16_pkg::UOP_JSR_WR;
                n_state   = i_stat.jsr_last ? acc16_pkg::S_JEND : acc16_pkg::S_JRD;
            end
            acc16_pkg::S_JEND: begin
                o_cmd.uop = acc16_pkg::UOP_JSR_END;
                n_state   = acc16_pkg::S_FIN;
            end
            acc16_pkg::S_FIN: begin
                // hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.uop   = acc16_pkg::UOP_FINISH;
                    n_out_valid = 1'b1;
                    n_state     = acc16_pkg::S_IDLE;
                end
            end
            default: n_state = acc16_pkg::S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

### hdl/accumulator_cpu_core_16bit_top.sv
// 16-bit accumulator processor with a 2^ADDR_BITS-word main store. After reset the
// block sweeps the store to zero, one word per cycle, so it accepts no item until
// all 2^ADDR_BITS words (65536 at the default) are cleared. An instruction is
// carried out as three fetch reads and an execute step on the single store port;
// POP and RET add a further step, PSA pushes all sixteen registers, POA pops them
// back, and JSR copies n+2 stack words, where n is the signed argument count on
// the stack (none when n is below -1). A finished result waits in its output
// register while the next item is accepted; that next item holds in its final
// state for as long as the earlier result still waits.
module accumulator_cpu_core_16bit_top #(
    parameter int ADDR_BITS = acc16_pkg::ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_address,
    input  logic [15:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_halted,
    output logic        o_bad_opcode,
    output logic [15:0] o_prog_counter,
    output logic [15:0] o_accum,
    output logic [15:0] o_stack_ptr,
    output logic [4:0]  o_flag_bits,
    output logic [15:0] o_read_data
);

    acc16_pkg::t_cmd  cmd;
    acc16_pkg::t_stat stat;

    acc16_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    acc16_dp #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_kind         (i_kind),
        .i_address      (i_address),
        .i_write_data   (i_write_data),
        .o_halted       (o_halted),
        .o_bad_opcode   (o_bad_opcode),
        .o_prog_counter (o_prog_counter),
        .o_accum        (o_accum),
        .o_stack_ptr    (o_stack_ptr),
        .o_flag_bits    (o_flag_bits),
        .o_read_data    (o_read_data)
    );

endmodule

### hdl/acc16_chk.sv
module acc16_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_halted,
    input logic        i_bad_opcode,
    input logic [15:0] i_prog_counter
);

    // One item at a time: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item accepted back to back");

    // A stopped core reports stopped until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_halted |=> i_halted)
        else $error("halted dropped without reset");

    // An invalid opcode always stops the core
    a_bad_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_bad_opcode |-> i_halted)
        else $error("bad opcode without halt");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_prog_counter))
        else $error("stalled result changed");

endmodule

bind accumulator_cpu_core_16bit_top acc16_chk u_acc16_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .i_in_ready     (o_in_ready),
    .i_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .i_halted       (o_halted),
    .i_bad_opcode   (o_bad_opcode),
    .i_prog_counter (o_prog_counter)
);
